// ----- design/spcq_pkg.sv -----
// ----------------------------------------------------------------------------
// spcq_pkg
// Shared widths and codes for the strict-priority class queue block.
// ----------------------------------------------------------------------------
package spcq_pkg;

  // Payload widths fixed by the channel definitions
  localparam int KIND_W        = 2;
  localparam int HANDLE_PORT_W = 16;
  localparam int MASK_W        = 4;
  localparam int STATUS_W      = 3;
  localparam int CLASS_PORT_W  = 2;
  localparam int LEVEL_W       = 7;

  // Configuration channel
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam int LEVEL_REGS = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_MASK = 3'd4;
  localparam logic [MASK_W-1:0]    DEFAULT_MASK_RST = 4'b1000;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEEK    = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ENQUEUED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_CLASS = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RETURNED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

endpackage

// ----- design/spcq_if.sv -----
// ----------------------------------------------------------------------------
// spcq_if
// Valid/ready channels of the strict-priority class queue block.
// ----------------------------------------------------------------------------
interface spcq_in_if;
  import spcq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic [HANDLE_PORT_W-1:0] packet_handle;
  logic [MASK_W-1:0]        match_mask;

  modport source (output valid, output kind, output packet_handle, output match_mask,
                  input ready);
  modport sink   (input valid, input kind, input packet_handle, input match_mask,
                  output ready);
endinterface

interface spcq_out_if;
  import spcq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [HANDLE_PORT_W-1:0] out_handle;
  logic [CLASS_PORT_W-1:0]  class_index;

  modport source (output valid, output status, output out_handle, output class_index,
                  input ready);
  modport sink   (input valid, input status, input out_handle, input class_index,
                  output ready);
endinterface

interface spcq_cfg_if;
  import spcq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- design/strict_priority_class_queues_unit.sv -----
// ----------------------------------------------------------------------------
// strict_priority_class_queues_unit
// Per-class handle FIFOs with strict-priority dequeue and head peek.
// ----------------------------------------------------------------------------
//
//  channel | dir | payload                              | transfer when
//  --------+-----+--------------------------------------+-------------------
//  req     | in  | kind, packet_handle, match_mask      | valid && ready
//  rsp     | out | status, out_handle, class_index      | valid && ready
//  cfg     | in  | index, data (register write)         | valid && ready
//
//  One item per cycle sustained while rsp is ready. A request transfer is
//  registered, decided (class select, count/head update, one store write
//  or read) and its result registered in the result stage.
//  The store has one write and one registered read port; one op per cycle.
//  rst (sync, active high) empties all queues and restores register values.
//  rsp stalls hold the result stage; req.ready drops only when both stages
//  are full. cfg is always ready.
//
module strict_priority_class_queues_unit #(
  parameter int NUM_CLASSES  = 4,
  parameter int FIFO_DEPTH   = 16,
  parameter int HANDLE_WIDTH = 16,
  parameter int LEVEL_LIMIT  = 100
) (
  input logic         clk,
  input logic         rst,
  spcq_in_if.sink     req,
  spcq_out_if.source  rsp,
  spcq_cfg_if.sink    cfg
);
  import spcq_pkg::*;

  localparam int CLS_W   = $clog2(NUM_CLASSES);
  localparam int HEAD_W  = $clog2(FIFO_DEPTH);
  localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
  localparam int ADDR_W  = $clog2(NUM_CLASSES * FIFO_DEPTH);
  localparam int NUM_SEL = (NUM_CLASSES < MASK_W) ? NUM_CLASSES : MASK_W;
  localparam int HEXT_W  = (HANDLE_WIDTH > HANDLE_PORT_W) ? HANDLE_WIDTH : HANDLE_PORT_W;
  localparam int CEXT_W  = (CLS_W > CLASS_PORT_W) ? CLS_W : CLASS_PORT_W;
  localparam int LIM_W   = LEVEL_W + 1;

  localparam logic [CNT_W:0]   DEPTH_SUM  = (CNT_W + 1)'(FIFO_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(FIFO_DEPTH);
  localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(FIFO_DEPTH - 1);
  localparam logic [ADDR_W-1:0] DEPTH_A   = ADDR_W'(FIFO_DEPTH);
  localparam logic [LIM_W-1:0] LIMIT      = LIM_W'(LEVEL_LIMIT);

  // Configuration registers
  logic [LEVEL_W-1:0] level [NUM_CLASSES];
  logic [MASK_W-1:0]  default_mask;

  // Queue state
  logic [HEAD_W-1:0]       head  [NUM_CLASSES];
  logic [CNT_W-1:0]        count [NUM_CLASSES];
  logic [CLS_W-1:0]        last_served;
  logic [HANDLE_WIDTH-1:0] store [NUM_CLASSES * FIFO_DEPTH];

  // Decision stage (registered request)
  logic                    a_valid;
  logic [KIND_W-1:0]       a_kind;
  logic [HANDLE_WIDTH-1:0] a_handle;
  logic [MASK_W-1:0]       a_match;
  logic                    a_adv;

  // Result stage
  logic                    b_valid;
  logic [STATUS_W-1:0]     b_status;
  logic [CLS_W-1:0]        b_cls;
  logic [HANDLE_WIDTH-1:0] rd_data;

  // Decision outputs
  logic                enq_found;
  logic [CLS_W-1:0]    enq_cls;
  logic                deq_found;
  logic [CLS_W-1:0]    deq_cls;
  logic [LEVEL_W-1:0]  deq_lvl;
  logic [CNT_W:0]      tail_sum;
  logic [HEAD_W-1:0]   tail_slot;
  logic [HEAD_W-1:0]   deq_head_next;
  logic [STATUS_W-1:0] d_status;
  logic [CLS_W-1:0]    d_cls;
  logic                d_wr;
  logic                d_deq;
  logic                d_rd;
  logic [ADDR_W-1:0]   wr_addr;
  logic [ADDR_W-1:0]   rd_addr;
  logic [CLS_W-1:0]    rd_cls;

  logic [HEXT_W-1:0]       in_ext;
  logic [HEXT_W-1:0]       out_ext;
  logic [CEXT_W-1:0]       cls_ext;

  // ---------------------------------------------------------------------
  // Handshakes: the decision stage moves on when the result stage is
  // empty or its result is taken in the same cycle.
  // ---------------------------------------------------------------------
  assign a_adv     = a_valid && (!b_valid || rsp.ready);
  assign req.ready = !a_valid || a_adv;
  assign cfg.ready = 1'b1;

  assign in_ext = HEXT_W'(req.packet_handle);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
    if (req.valid && req.ready) begin
      a_kind   <= req.kind;
      a_handle <= in_ext[HANDLE_WIDTH-1:0];  // handles kept at HANDLE_WIDTH bits
      a_match  <= req.match_mask;
    end
  end

  // ---------------------------------------------------------------------
  // Class selection
  // ---------------------------------------------------------------------
  always_comb begin
    // Enqueue: lowest matching filter, else highest default class
    enq_found = 1'b0;
    enq_cls   = '0;
    for (int i = NUM_SEL - 1; i >= 0; i--) begin
      if (a_match[i]) begin
        enq_found = 1'b1;
        enq_cls   = CLS_W'(i);
      end
    end
    if (!enq_found) begin
      for (int i = 0; i < NUM_SEL; i++) begin
        if (default_mask[i]) begin
          enq_found = 1'b1;
          enq_cls   = CLS_W'(i);
        end
      end
    end

    // Dequeue: lowest servable level, ties to the lowest index
    deq_found = 1'b0;
    deq_cls   = '0;
    deq_lvl   = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      if (count[i] != '0 && LIM_W'(level[i]) < LIMIT &&
          (!deq_found || level[i] < deq_lvl)) begin
        deq_found = 1'b1;
        deq_cls   = CLS_W'(i);
        deq_lvl   = level[i];
      end
    end
  end

  // Tail slot: head + count wraps at most once
  always_comb begin
    tail_sum = (CNT_W + 1)'(head[enq_cls]) + (CNT_W + 1)'(count[enq_cls]);
    if (tail_sum >= DEPTH_SUM) begin
      tail_sum = tail_sum - DEPTH_SUM;
    end
    tail_slot = tail_sum[HEAD_W-1:0];
  end

  assign deq_head_next = (head[deq_cls] == HEAD_LAST) ? '0 : head[deq_cls] + 1'b1;

  always_comb begin
    d_status = ST_EMPTY;
    d_cls    = '0;
    d_wr     = 1'b0;
    d_deq    = 1'b0;
    d_rd     = 1'b0;
    rd_cls   = last_served;
    unique case (a_kind)
      KIND_ENQUEUE: begin
        if (!enq_found) begin
          d_status = ST_NO_CLASS;
        end else if (count[enq_cls] >= DEPTH_CNT) begin
          d_status = ST_FULL;
          d_cls    = enq_cls;
        end else begin
          d_status = ST_ENQUEUED;
          d_cls    = enq_cls;
          d_wr     = 1'b1;
        end
      end
      KIND_DEQUEUE: begin
        if (deq_found) begin
          d_status = ST_RETURNED;
          d_cls    = deq_cls;
          d_deq    = 1'b1;
          d_rd     = 1'b1;
          rd_cls   = deq_cls;
        end
      end
      KIND_PEEK: begin
        d_cls = last_served;
        if (count[last_served] != '0) begin
          d_status = ST_RETURNED;
          d_rd     = 1'b1;
        end
      end
      default: begin
        // unused operation code: empty result, no state change
      end
    endcase
  end

  assign wr_addr = ADDR_W'(enq_cls) * DEPTH_A + ADDR_W'(tail_slot);
  assign rd_addr = ADDR_W'(rd_cls) * DEPTH_A + ADDR_W'(head[rd_cls]);

  // ---------------------------------------------------------------------
  // Queue state and configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        head[i]  <= '0;
        count[i] <= '0;
        level[i] <= LEVEL_W'(i);
      end
      last_served  <= '0;
      default_mask <= DEFAULT_MASK_RST;
    end else begin
      if (a_adv && d_wr) begin
        count[enq_cls] <= count[enq_cls] + 1'b1;
      end
      if (a_adv && d_deq) begin
        head[deq_cls]  <= deq_head_next;
        count[deq_cls] <= count[deq_cls] - 1'b1;
        last_served    <= deq_cls;
      end
      if (cfg.valid && cfg.ready) begin
        // classes past the level registers keep their reset level
        for (int i = 0; i < NUM_CLASSES; i++) begin
          if (i < LEVEL_REGS && cfg.index == CFG_IDX_W'(i)) begin
            level[i] <= cfg.data[LEVEL_W-1:0];
          end
        end
        if (cfg.index == CFG_DEFAULT_MASK) begin
          default_mask <= cfg.data[MASK_W-1:0];
        end
      end
    end
  end

  // Handle store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (a_adv && d_wr) begin
      store[wr_addr] <= a_handle;
    end
    if (a_adv) begin
      rd_data <= d_rd ? store[rd_addr] : '0;
    end
  end

  // ---------------------------------------------------------------------
  // Result stage
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_adv) begin
      b_valid <= 1'b1;
    end else if (rsp.ready) begin
      b_valid <= 1'b0;
    end
    if (a_adv) begin
      b_status <= d_status;
      b_cls    <= d_cls;
    end
  end

  assign out_ext = HEXT_W'(rd_data);
  assign cls_ext = CEXT_W'(b_cls);

  assign rsp.valid       = b_valid;
  assign rsp.status      = b_status;
  assign rsp.out_handle  = out_ext[HANDLE_PORT_W-1:0];
  assign rsp.class_index = cls_ext[CLASS_PORT_W-1:0];

endmodule
